[hw/rtl/mft_pkg.sv]
// Shared types and constants of the multicast forwarding table.
// No dependencies; used by every module of the block.
`default_nettype none
package mft_pkg;
	localparam int RULE_ENTRIES = 64;
	localparam int NODE_ENTRIES = 32;
	localparam int PORT_COUNT = 16;
	localparam int COUNT_WIDTH = 16;
	localparam int RIDX_W = $clog2(RULE_ENTRIES);
	localparam int NIDX_W = $clog2(NODE_ENTRIES);

	localparam logic [2:0] OP_BIND = 3'd0;
	localparam logic [2:0] OP_UNBIND = 3'd1;
	localparam logic [2:0] OP_ADD = 3'd2;
	localparam logic [2:0] OP_DELETE = 3'd3;
	localparam logic [2:0] OP_FORWARD = 3'd4;

	localparam logic [1:0] ST_ACK = 2'd0;
	localparam logic [1:0] ST_NACK = 2'd1;
	localparam logic [1:0] ST_FWD = 2'd2;
	localparam logic [1:0] ST_NOROUTE = 2'd3;

	typedef struct packed {
		logic [2:0] op;
		logic [31:0] group_id;
		logic [31:0] node_id;
		logic [3:0] port;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] out_port;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] group;
		logic [3:0] port;
		logic [COUNT_WIDTH-1:0] count;
	} rule_t;

	typedef struct packed {
		logic load;
		logic look;
		logic scan;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_end;
	} dp_sts_t;
endpackage
`default_nettype wire

[hw/rtl/mft_ctrl.sv]
// Sequencer of the forwarding table: load, node lookup, rule scan, commit.
// Depends on mft_pkg.
`default_nettype none
module mft_ctrl import mft_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire dp_sts_t sts,
	output ctl_cmd_t cmd
);
	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_SCAN, S_DRAIN, S_DONE} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (start) state_q <= S_LOOK;
				S_LOOK: state_q <= S_SCAN;
				S_SCAN: if (sts.scan_end) state_q <= S_DRAIN;
				S_DRAIN: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load = (state_q == S_IDLE) && start;
		cmd.look = (state_q == S_LOOK);
		cmd.scan = (state_q == S_SCAN);
		cmd.finish = (state_q == S_DONE);
	end
	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

[hw/rtl/mft_dp.sv]
// Datapath: node map in flops, rule table in a RAM scanned one entry a cycle.
// Depends on mft_pkg.
`default_nettype none
module mft_dp import mft_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire req_t request,
	input wire ctl_cmd_t cmd,
	output dp_sts_t sts,
	output rsp_t result,
	output logic result_strobe
);
	req_t req_q;
	logic [NODE_ENTRIES-1:0] node_valid_q;
	logic [31:0] node_ident_q [NODE_ENTRIES];
	logic [3:0] node_port_q [NODE_ENTRIES];
	logic node_hit_q, node_free_q;
	logic [NIDX_W-1:0] node_idx_q, node_free_idx_q;
	logic [3:0] node_pt_q;

	logic [RULE_ENTRIES-1:0] rule_valid_q;
	rule_t rule_mem [RULE_ENTRIES];
	logic [RIDX_W-1:0] addr_q, ridx_s1;
	rule_t rd_s1;
	logic rv_s1, act_s1;
	logic hit_q, free_q;
	logic [RIDX_W-1:0] hit_idx_q, free_idx_q;
	logic [COUNT_WIDTH-1:0] hit_cnt_q;
	logic pend_q;
	logic [3:0] pend_port_q;
	rsp_t result_q;
	logic strobe_q;

	// node map lookup, parallel compare over all entries
	logic n_hit, n_free;
	logic [NIDX_W-1:0] n_idx, n_free_idx;
	always_comb begin
		n_hit = 1'b0;
		n_free = 1'b0;
		n_idx = '0;
		n_free_idx = '0;
		for (int i = NODE_ENTRIES - 1; i >= 0; i--) begin
			if (node_valid_q[i] && node_ident_q[i] == req_q.node_id) begin
				n_hit = 1'b1;
				n_idx = NIDX_W'(i);
			end
			if (!node_valid_q[i]) begin
				n_free = 1'b1;
				n_free_idx = NIDX_W'(i);
			end
		end
	end

	logic is_fwd, s_match, fwd_emit;
	assign is_fwd = (req_q.op == OP_FORWARD);
	assign s_match = act_s1 && rv_s1 && rd_s1.group == req_q.group_id
		&& (is_fwd || rd_s1.port == node_pt_q);
	// a new match of a forward releases the previously held port
	assign fwd_emit = s_match && is_fwd && pend_q;
	assign sts.scan_end = (addr_q == RIDX_W'(RULE_ENTRIES - 1));

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
	logic port_ok;
	assign port_ok = ({28'd0, req_q.port} < 32'(PORT_COUNT));

	// closing result of the item
	rsp_t fin_rsp;
	always_comb begin
		fin_rsp = '{status: ST_ACK, out_port: 4'd0, last: 1'b1};
		case (req_q.op)
			OP_BIND: begin
				if (!port_ok || (!node_hit_q && !node_free_q))
					fin_rsp.status = ST_NACK;
			end
			OP_UNBIND, OP_DELETE: fin_rsp.status = ST_ACK;
			OP_ADD: begin
				if (!node_hit_q || (!hit_q && !free_q))
					fin_rsp.status = ST_NACK;
			end
			OP_FORWARD: begin
				if (pend_q) begin
					fin_rsp.status = ST_FWD;
					fin_rsp.out_port = pend_port_q;
				end else begin
					fin_rsp.status = ST_NOROUTE;
				end
			end
			default: fin_rsp.status = ST_NACK;
		endcase
	end

	// rule RAM: one read port for the scan, one write port for the commit
	logic mem_we;
	logic [RIDX_W-1:0] mem_wa;
	rule_t mem_wd;
	always_comb begin
		mem_we = 1'b0;
		mem_wa = hit_idx_q;
		mem_wd = '{group: req_q.group_id, port: node_pt_q, count: CNT_ONE};
		if (cmd.finish && node_hit_q) begin
			if (req_q.op == OP_ADD) begin
				if (hit_q) begin
					mem_we = 1'b1;
					mem_wd.count = (hit_cnt_q == CNT_MAX) ? hit_cnt_q : hit_cnt_q + CNT_ONE;
				end else if (free_q) begin
					mem_we = 1'b1;
					mem_wa = free_idx_q;
				end
			end else if (req_q.op == OP_DELETE && hit_q && hit_cnt_q > CNT_ONE) begin
				mem_we = 1'b1;
				mem_wd.count = hit_cnt_q - CNT_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) rule_mem[mem_wa] <= mem_wd;
		if (cmd.scan) rd_s1 <= rule_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= request;
		if (cmd.scan) begin
			rv_s1 <= rule_valid_q[addr_q];
			ridx_s1 <= addr_q;
		end
		if (cmd.look) begin
			node_idx_q <= n_idx;
			node_free_idx_q <= n_free_idx;
			node_pt_q <= node_port_q[n_idx];
		end
		if (cmd.finish && req_q.op == OP_BIND && port_ok && !node_hit_q && node_free_q) begin
			node_ident_q[node_free_idx_q] <= req_q.node_id;
			node_port_q[node_free_idx_q] <= req_q.port;
		end
		if (s_match && !hit_q) begin
			hit_idx_q <= ridx_s1;
			hit_cnt_q <= rd_s1.count;
		end
		if (act_s1 && !rv_s1 && !free_q) free_idx_q <= ridx_s1;
		if (s_match) pend_port_q <= rd_s1.port;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_valid_q <= '0;
			rule_valid_q <= '0;
			node_hit_q <= 1'b0;
			node_free_q <= 1'b0;
			addr_q <= '0;
			act_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			pend_q <= 1'b0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			act_s1 <= cmd.scan;
			strobe_q <= cmd.finish || fwd_emit;
			if (cmd.finish)
				result_q <= fin_rsp;
			else if (fwd_emit)
				result_q <= '{status: ST_FWD, out_port: pend_port_q, last: 1'b0};
			if (cmd.load) begin
				addr_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				pend_q <= 1'b0;
			end
			if (cmd.look) begin
				node_hit_q <= n_hit;
				node_free_q <= n_free;
			end
			if (cmd.scan) addr_q <= addr_q + RIDX_W'(1);
			if (s_match) begin
				hit_q <= 1'b1;
				pend_q <= 1'b1;
			end
			if (act_s1 && !rv_s1) free_q <= 1'b1;
			if (cmd.finish) begin
				case (req_q.op)
					OP_BIND: begin
						if (port_ok && !node_hit_q && node_free_q)
							node_valid_q[node_free_idx_q] <= 1'b1;
					end
					OP_UNBIND: if (node_hit_q) node_valid_q[node_idx_q] <= 1'b0;
					OP_ADD: begin
						if (node_hit_q && !hit_q && free_q)
							rule_valid_q[free_idx_q] <= 1'b1;
					end
					OP_DELETE: begin
						if (node_hit_q && hit_q && hit_cnt_q <= CNT_ONE)
							rule_valid_q[hit_idx_q] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign result = result_q;
	assign result_strobe = strobe_q;
endmodule
`default_nettype wire

[hw/rtl/multicast_forwarding_table.sv]
// Top level of the multicast forwarding table: controller plus datapath.
// Depends on mft_pkg, mft_ctrl and mft_dp.
//
// Every item, whatever the operation, scans the whole rule table between
// start and the final result: the rule table sits in a RAM with one read
// and one write port, and each item sweeps it one entry per cycle to find
// the matching entry, the first free entry or all entries of a group. The
// node map is searched in parallel. Results come out on result, flagged by
// result_strobe for one cycle each; the receiver cannot stall them. A
// forward gives one result per port of the group in ascending entry order,
// the last one marked, or a single no-route result. The final result is
// presented in the first cycle with busy low, so a new item may be started
// in that same cycle.
`default_nettype none
module multicast_forwarding_table import mft_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire req_t request,
	output rsp_t result,
	output logic result_strobe
);
	ctl_cmd_t cmd;
	dp_sts_t sts;

	mft_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	mft_dp u_dp (
		.clk(clk), .arst_n(arst_n), .request(request), .cmd(cmd), .sts(sts),
		.result(result), .result_strobe(result_strobe)
	);

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item accepted but not busy");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |=> !result_strobe) else $error("result after last");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !result_strobe) else $error("result while idle");
`endif
endmodule
`default_nettype wire

[bench/tb_multicast_forwarding_table.sv]
// Testbench for the multicast forwarding table: node binding, rule add and
// delete with reference counts, and forwarding lookups, checked against an
// in-bench predictor. Depends on mft_pkg and multicast_forwarding_table.
`timescale 1ns / 100ps
`default_nettype none
module tb_multicast_forwarding_table;
	import mft_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t request = '0;
	rsp_t result;
	logic result_strobe;

	multicast_forwarding_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.result(result),
		.result_strobe(result_strobe)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the table and node map
	bit rule_used[RULE_ENTRIES];
	logic [31:0] rule_grp[RULE_ENTRIES];
	logic [3:0] rule_prt[RULE_ENTRIES];
	logic [COUNT_WIDTH-1:0] rule_cnt[RULE_ENTRIES];
	bit node_used[NODE_ENTRIES];
	logic [31:0] node_id_tab[NODE_ENTRIES];
	logic [3:0] node_prt[NODE_ENTRIES];

	rsp_t pending_rsp[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int forwards_hit = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;

	// id pool keeps random traffic hitting bound nodes and live groups
	logic [31:0] id_pool[8];
	logic [31:0] grp_pool[6];

	function automatic int node_lookup(logic [31:0] id);
		for (int i = 0; i < NODE_ENTRIES; i++)
			if (node_used[i] && node_id_tab[i] == id) return i;
		return -1;
	endfunction

	function automatic int rule_lookup(logic [31:0] g, logic [3:0] p);
		for (int i = 0; i < RULE_ENTRIES; i++)
			if (rule_used[i] && rule_grp[i] == g && rule_prt[i] == p) return i;
		return -1;
	endfunction

	function automatic rsp_t one_rsp(logic [1:0] st);
		rsp_t r;
		r.status = st;
		r.out_port = '0;
		r.last = 1'b1;
		return r;
	endfunction

	// appends one expected result
	task automatic queue_rsp(rsp_t r);
		pending_rsp.insert(pending_rsp.size(), r);
	endtask

	// applies one item to the model state and queues its results
	task automatic predict_table(req_t q);
		int n;
		int r;
		int k;
		logic [1:0] st;
		rsp_t f;
		case (q.op)
			OP_BIND: begin
				st = ST_NACK;
				if (q.port < PORT_COUNT) begin
					if (node_lookup(q.node_id) >= 0) st = ST_ACK;
					else
						for (int i = 0; i < NODE_ENTRIES; i++)
							if (!node_used[i]) begin
								node_used[i] = 1'b1;
								node_id_tab[i] = q.node_id;
								node_prt[i] = q.port;
								st = ST_ACK;
								break;
							end
				end
				queue_rsp(one_rsp(st));
			end
			OP_UNBIND: begin
				n = node_lookup(q.node_id);
				if (n >= 0) node_used[n] = 1'b0;
				queue_rsp(one_rsp(ST_ACK));
			end
			OP_ADD: begin
				st = ST_NACK;
				n = node_lookup(q.node_id);
				if (n >= 0) begin
					r = rule_lookup(q.group_id, node_prt[n]);
					if (r >= 0) begin
						if (rule_cnt[r] != COUNT_TOP) rule_cnt[r]++;
						st = ST_ACK;
					end else
						for (int i = 0; i < RULE_ENTRIES; i++)
							if (!rule_used[i]) begin
								rule_used[i] = 1'b1;
								rule_grp[i] = q.group_id;
								rule_prt[i] = node_prt[n];
								rule_cnt[i] = COUNT_WIDTH'(1);
								st = ST_ACK;
								break;
							end
				end
				queue_rsp(one_rsp(st));
			end
			OP_DELETE: begin
				n = node_lookup(q.node_id);
				if (n >= 0) begin
					r = rule_lookup(q.group_id, node_prt[n]);
					if (r >= 0) begin
						if (rule_cnt[r] <= 1) rule_used[r] = 1'b0;
						else rule_cnt[r]--;
					end
				end
				queue_rsp(one_rsp(ST_ACK));
			end
			OP_FORWARD: begin
				k = 0;
				f = '0;
				// each port is queued once the next one is known, the last one marked
				for (int i = 0; i < RULE_ENTRIES && k < 16; i++)
					if (rule_used[i] && rule_grp[i] == q.group_id) begin
						if (k > 0) queue_rsp(f);
						f.status = ST_FWD;
						f.out_port = rule_prt[i];
						f.last = 1'b0;
						k++;
					end
				if (k == 0) queue_rsp(one_rsp(ST_NOROUTE));
				else begin
					f.last = 1'b1;
					queue_rsp(f);
					forwards_hit++;
				end
			end
			default: queue_rsp(one_rsp(ST_NACK));
		endcase
	endtask

	// sends one item: waits for idle, optional random gap, then holds start until accepted
	task automatic send_item(logic [2:0] op, logic [31:0] g, logic [31:0] id,
			logic [3:0] p);
		req_t q;
		q.op = op;
		q.group_id = g;
		q.node_id = id;
		q.port = p;
		while (busy) @(posedge clk);
		while (!no_gaps && $urandom_range(99) < 18) @(posedge clk);
		start <= 1'b1;
		request <= q;
		do @(posedge clk); while (busy);
		predict_table(q);
		items_sent++;
		start <= 1'b0;
		@(posedge clk);
	endtask

	// result checker: strobe is sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			results_seen++;
			if (pending_rsp.size() == 0) begin
				$error("result with nothing expected: %p", result);
				errors++;
			end else begin
				rsp_t e;
				e = pending_rsp.pop_front();
				if (result.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, result.status);
					errors++;
				end
				if (result.out_port !== e.out_port) begin
					$error("out_port: expected %0d, got %0d", e.out_port,
						result.out_port);
					errors++;
				end
				if (result.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, result.last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted item and no result
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d quiet cycles", IDLE_LIMIT);
			$display("tb_multicast_forwarding_table: FAIL");
			$finish;
		end
	end

	task automatic test_node_map();
		send_item(OP_UNBIND, '0, 32'h0000_0000, 4'd0);   // unbound node
		send_item(OP_BIND, '0, 32'h0000_0000, 4'd0);
		send_item(OP_BIND, '1, 32'hFFFF_FFFF, 4'd15);
		send_item(OP_BIND, '0, 32'hFFFF_FFFF, 4'd3);     // already bound, kept
		send_item(3'd5, '1, '1, 4'd15);                  // undefined ops
		send_item(3'd6, '0, '0, 4'd0);
		send_item(3'd7, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 4'd9);
	endtask

	task automatic test_rules();
		send_item(OP_FORWARD, 32'h1234_5678, '0, 4'd0);  // no route
		send_item(OP_ADD, 32'h1234_5678, 32'hDEAD_BEEF, 4'd0); // unbound node
		send_item(OP_ADD, '1, 32'h0000_0000, 4'd0);
		send_item(OP_ADD, '1, 32'hFFFF_FFFF, 4'd0);
		send_item(OP_ADD, '1, 32'hFFFF_FFFF, 4'd0);
		send_item(OP_FORWARD, '1, '0, 4'd0);
		send_item(OP_DELETE, '1, 32'hFFFF_FFFF, 4'd0);
		send_item(OP_DELETE, '1, 32'hFFFF_FFFF, 4'd0);   // frees entry
		send_item(OP_DELETE, '1, 32'hFFFF_FFFF, 4'd0);   // no matching entry
		send_item(OP_DELETE, '1, 32'h7777_7777, 4'd0);   // unbound node
		send_item(OP_FORWARD, '1, '0, 4'd0);
		send_item(OP_UNBIND, '0, 32'h0000_0000, 4'd0);   // rules stay
		send_item(OP_FORWARD, '1, '0, 4'd0);
	endtask

	// fills the node map, refuses one more, then a group on all sixteen ports
	task automatic test_full_map();
		for (int i = 0; i < NODE_ENTRIES; i++)
			send_item(OP_BIND, '0, 32'h100 + i, 4'(i));
		send_item(OP_BIND, '0, 32'h200, 4'd1);
		for (int i = 0; i < 16; i++)
			send_item(OP_ADD, 32'hCAFE_0000, 32'h100 + i, 4'd0);
		send_item(OP_FORWARD, 32'hCAFE_0000, '0, 4'd0);
	endtask

	// fills the rule table and checks refusal of one more
	task automatic test_full_table();
		for (int i = 0; i < RULE_ENTRIES; i++)
			send_item(OP_ADD, 32'hF000_0000 + i, 32'h100 + (i % 16), 4'd0);
		send_item(OP_ADD, 32'hEEEE_EEEE, 32'h101, 4'd0);
		send_item(OP_ADD, 32'hCAFE_0000, 32'h102, 4'd0);  // existing, ack
	endtask

	// mostly pooled ids so that adds, deletes and forwards find state
	task automatic test_random(int count);
		logic [2:0] op;
		logic [31:0] g;
		logic [31:0] id;
		for (int i = 0; i < 8; i++) id_pool[i] = $urandom;
		for (int i = 0; i < 6; i++) grp_pool[i] = $urandom;
		for (int n = 0; n < count; n++) begin
			no_gaps = (n >= count / 2 && n < count / 2 + 30);
			op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(4));
			g = ($urandom_range(9) == 0) ? $urandom : grp_pool[$urandom_range(5)];
			id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(7)];
			send_item(op, g, id, 4'($urandom));
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_node_map();
		test_rules();
		test_random(70);
		test_full_map();
		test_full_table();
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		$display("sent %0d items, checked %0d results, %0d forwards with routes",
			items_sent, results_seen, forwards_hit);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("tb_multicast_forwarding_table: PASS");
		else
			$display("tb_multicast_forwarding_table: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
hw/rtl/mft_pkg.sv
hw/rtl/mft_ctrl.sv
hw/rtl/mft_dp.sv
hw/rtl/multicast_forwarding_table.sv
bench/tb_multicast_forwarding_table.sv
